// File: sv/multi_pattern_text_matcher_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-pattern text matcher
// Shared property wrappers; every user module has i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_TEXT_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_TEXT_MATCHER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define MPTM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define MPTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mptm_pkg.sv
// ----------------------------------------------------------------------------
// mptm_pkg
// Sizes, request codes and the match job type shared by the matcher modules.
// ----------------------------------------------------------------------------
package mptm_pkg;

    // Sizing
    localparam int NUM_PATTERNS    = 8;
    localparam int MAX_PATTERN_LEN = 16;
    localparam int POS_BITS        = 32;
    localparam int MAX_REPORTS     = 8;
    localparam int FIFO_DEPTH      = 4;

    // Request and report field widths
    localparam int FUNC_W  = 2;
    localparam int SLOT_W  = 3;
    localparam int CPOS_W  = 4;
    localparam int PLEN_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 32;

    // Derived widths
    localparam int LEN_W      = $clog2(MAX_PATTERN_LEN + 1);
    localparam int SLOT_IDX_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int HIST_IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int RPT_W      = (MAX_REPORTS > 1) ? $clog2(MAX_REPORTS) : 1;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int WIDE_W     = (POS_BITS > INDEX_W) ? POS_BITS : INDEX_W;

    // Request codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PAT_BYTE = 2'd0,
        FUNC_PAT_LEN  = 2'd1,
        FUNC_TEXT     = 2'd2,
        FUNC_RESTART  = 2'd3
    } t_func;

    // One text byte that hit at least one pattern
    typedef struct packed {
        logic [NUM_PATTERNS-1:0]            mask;
        logic [POS_BITS-1:0]                count;
        logic [NUM_PATTERNS-1:0][LEN_W-1:0] lens;
    } t_job;

endpackage

// File: sv/multi_pattern_text_matcher.sv
// ----------------------------------------------------------------------------
// multi_pattern_text_matcher
// Exact multi-pattern search over a byte stream with up to eight patterns.
// ----------------------------------------------------------------------------
// Requests are accepted one per clock while the four-entry match queue has
// room. Pattern byte, pattern length and restart requests take effect in the
// cycle they are accepted; a text byte is compared against every enabled
// pattern in that same cycle, and when at least one pattern hits, one entry
// (hit mask, position, lengths) is queued. The back end drains the queue at
// one report per cycle while the output is ready, lowest slot first, with last
// marking the final report for the byte; a report passes from its queue entry
// through the job registers and the output register. Sustained throughput is
// one text byte per cycle as long as hits average at most one report per byte;
// dense hits stall input through the full queue, and the report drain sets the pace.
module multi_pattern_text_matcher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [mptm_pkg::FUNC_W-1:0]    i_func,
    input  logic [mptm_pkg::SLOT_W-1:0]    i_slot,
    input  logic [mptm_pkg::CPOS_W-1:0]    i_char_pos,
    input  logic [mptm_pkg::PLEN_W-1:0]    i_pattern_len,
    input  logic [mptm_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mptm_pkg::SLOT_W-1:0]    o_match_slot,
    output logic [mptm_pkg::INDEX_W-1:0]   o_start_index,
    output logic                           o_last
);

    logic           w_push;
    logic           w_pop;
    logic           w_q_valid;
    logic           w_q_full;
    mptm_pkg::t_job w_push_job;
    mptm_pkg::t_job w_pop_job;

    // Request handling and compare
    mptm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_func        (i_func),
        .i_slot        (i_slot),
        .i_char_pos    (i_char_pos),
        .i_pattern_len (i_pattern_len),
        .i_data_byte   (i_data_byte),
        .i_full        (w_q_full),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    // Hit queue
    mptm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_job   (w_pop_job)
    );

    // Report sequencing
    mptm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_job       (w_pop_job),
        .o_q_pop       (w_pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_match_slot  (o_match_slot),
        .o_start_index (o_start_index),
        .o_last        (o_last)
    );

endmodule

// File: sv/mptm_front.sv
// ----------------------------------------------------------------------------
// mptm_front
// Takes requests, holds patterns, lengths, text history and position, and
// compares every enabled pattern against the window ending at each text byte.
// ----------------------------------------------------------------------------
module mptm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mptm_pkg::FUNC_W-1:0]   i_func,
    input  logic [mptm_pkg::SLOT_W-1:0]   i_slot,
    input  logic [mptm_pkg::CPOS_W-1:0]   i_char_pos,
    input  logic [mptm_pkg::PLEN_W-1:0]   i_pattern_len,
    input  logic [mptm_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_full,
    output logic                          o_push,
    output mptm_pkg::t_job                o_job
);

    // Pattern bytes: each one feeds its own comparator
    logic [mptm_pkg::BYTE_W-1:0] r_pat [mptm_pkg::NUM_PATTERNS][mptm_pkg::MAX_PATTERN_LEN];
    logic [mptm_pkg::LEN_W-1:0]  r_len [mptm_pkg::NUM_PATTERNS];
    // History, newest byte at index 0
    logic [mptm_pkg::BYTE_W-1:0] r_hist [mptm_pkg::MAX_PATTERN_LEN];
    logic [mptm_pkg::POS_BITS-1:0] r_count;

    logic [mptm_pkg::BYTE_W-1:0]   n_hist [mptm_pkg::MAX_PATTERN_LEN];
    logic [mptm_pkg::POS_BITS-1:0] n_count;
    logic [mptm_pkg::NUM_PATTERNS-1:0] w_mask;
    logic [mptm_pkg::LEN_W-1:0]    w_off;
    logic [mptm_pkg::LEN_W-1:0]    w_len_sat;
    logic                          w_accept;
    logic                          w_text;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_text   = w_accept && (i_func == mptm_pkg::FUNC_TEXT);

    // Length request saturates at the longest pattern
    assign w_len_sat = (int'(i_pattern_len) > mptm_pkg::MAX_PATTERN_LEN)
                     ? mptm_pkg::LEN_W'(mptm_pkg::MAX_PATTERN_LEN)
                     : mptm_pkg::LEN_W'(i_pattern_len);

    // History shifted by the incoming byte, position saturating
    always_comb begin
        n_hist[0] = i_data_byte;
        for (int k = 1; k < mptm_pkg::MAX_PATTERN_LEN; k++) begin
            n_hist[k] = r_hist[k-1];
        end
        n_count = (r_count == '1) ? r_count : r_count + 1'b1;
    end

    // Exact compare of each slot against the window of its own length
    always_comb begin
        w_off = '0;
        for (int s = 0; s < mptm_pkg::NUM_PATTERNS; s++) begin
            w_mask[s] = (r_len[s] != '0) &&
                        (mptm_pkg::WIDE_W'(n_count) >= mptm_pkg::WIDE_W'(r_len[s]));
            for (int i = 0; i < mptm_pkg::MAX_PATTERN_LEN; i++) begin
                if (mptm_pkg::LEN_W'(i) < r_len[s]) begin
                    w_off = r_len[s] - mptm_pkg::LEN_W'(i) - mptm_pkg::LEN_W'(1);
                    if (r_pat[s][i] != n_hist[w_off[mptm_pkg::HIST_IDX_W-1:0]]) begin
                        w_mask[s] = 1'b0;
                    end
                end
            end
        end
    end

    // Only text bytes with a hit go to the queue
    always_comb begin
        o_push     = w_text && (w_mask != '0);
        o_job.mask = w_mask;
        o_job.count = n_count;
        for (int s = 0; s < mptm_pkg::NUM_PATTERNS; s++) begin
            o_job.lens[s] = r_len[s];
        end
    end

    // Pattern byte store, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_func == mptm_pkg::FUNC_PAT_BYTE)) begin
            for (int s = 0; s < mptm_pkg::NUM_PATTERNS; s++) begin
                for (int i = 0; i < mptm_pkg::MAX_PATTERN_LEN; i++) begin
                    if ((int'(i_slot) == s) && (int'(i_char_pos) == i)) begin
                        r_pat[s][i] <= i_data_byte;
                    end
                end
            end
        end
    end

    // Lengths, history and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < mptm_pkg::NUM_PATTERNS; s++) begin
                r_len[s] <= '0;
            end
            for (int k = 0; k < mptm_pkg::MAX_PATTERN_LEN; k++) begin
                r_hist[k] <= '0;
            end
            r_count <= '0;
        end else if (w_accept) begin
            case (i_func)
                mptm_pkg::FUNC_PAT_LEN: begin
                    for (int s = 0; s < mptm_pkg::NUM_PATTERNS; s++) begin
                        if (int'(i_slot) == s) begin
                            r_len[s] <= w_len_sat;
                        end
                    end
                end
                mptm_pkg::FUNC_TEXT: begin
                    r_hist  <= n_hist;
                    r_count <= n_count;
                end
                mptm_pkg::FUNC_RESTART: begin
                    for (int k = 0; k < mptm_pkg::MAX_PATTERN_LEN; k++) begin
                        r_hist[k] <= '0;
                    end
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: sv/mptm_queue.sv
// ----------------------------------------------------------------------------
// mptm_queue
// Small first-in first-out buffer of match jobs between front and back.
// ----------------------------------------------------------------------------
`include "multi_pattern_text_matcher_assert.svh"

module mptm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mptm_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output mptm_pkg::t_job o_job
);

    mptm_pkg::t_job                r_mem [mptm_pkg::FIFO_DEPTH];
    logic [mptm_pkg::PTR_W-1:0]    r_wr_ptr;
    logic [mptm_pkg::PTR_W-1:0]    r_rd_ptr;
    logic [mptm_pkg::FCNT_W-1:0]   r_cnt;

    logic [mptm_pkg::PTR_W-1:0]    n_wr_ptr;
    logic [mptm_pkg::PTR_W-1:0]    n_rd_ptr;
    logic                          w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == mptm_pkg::FCNT_W'(mptm_pkg::FIFO_DEPTH));
    assign o_job   = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    // Wrapping pointers
    assign n_wr_ptr = (r_wr_ptr == mptm_pkg::PTR_W'(mptm_pkg::FIFO_DEPTH - 1))
                    ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == mptm_pkg::PTR_W'(mptm_pkg::FIFO_DEPTH - 1))
                    ? '0 : r_rd_ptr + 1'b1;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `MPTM_ASSERT_SAME(a_no_push_full, i_push, !o_full, "match queue overflow")
    `MPTM_ASSERT_SAME(a_cnt_bound, 1'b1, r_cnt <= mptm_pkg::FCNT_W'(mptm_pkg::FIFO_DEPTH), "match queue level out of range")

endmodule

// File: sv/mptm_back.sv
// ----------------------------------------------------------------------------
// mptm_back
// Walks the hit mask of each queued job, lowest slot first, and emits one
// report per cycle, while the output is ready, through an output register.
// ----------------------------------------------------------------------------
`include "multi_pattern_text_matcher_assert.svh"

module mptm_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  mptm_pkg::t_job                 i_q_job,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [mptm_pkg::SLOT_W-1:0]    o_match_slot,
    output logic [mptm_pkg::INDEX_W-1:0]   o_start_index,
    output logic                           o_last
);

    // Job being reported
    logic                                        r_busy;
    logic [mptm_pkg::NUM_PATTERNS-1:0]           r_mask;
    logic [mptm_pkg::POS_BITS-1:0]               r_count;
    logic [mptm_pkg::NUM_PATTERNS-1:0][mptm_pkg::LEN_W-1:0] r_lens;
    logic [mptm_pkg::RPT_W-1:0]                  r_rpt;

    // Output register
    logic                                        r_out_valid;
    logic [mptm_pkg::SLOT_W-1:0]                 r_slot;
    logic [mptm_pkg::INDEX_W-1:0]                r_start;
    logic                                        r_last;

    logic [mptm_pkg::SLOT_IDX_W-1:0]             w_sel;
    logic [mptm_pkg::NUM_PATTERNS-1:0]           w_rest;
    logic [mptm_pkg::WIDE_W-1:0]                 w_diff;
    logic                                        w_adv;
    logic                                        w_last;

    // Lowest pending slot
    always_comb begin
        w_sel = '0;
        for (int s = mptm_pkg::NUM_PATTERNS - 1; s >= 0; s--) begin
            if (r_mask[s]) begin
                w_sel = mptm_pkg::SLOT_IDX_W'(s);
            end
        end
    end

    assign w_rest  = r_mask & (r_mask - 1'b1);
    assign w_diff  = mptm_pkg::WIDE_W'(r_count) - mptm_pkg::WIDE_W'(r_lens[w_sel]);
    assign w_adv   = r_busy && (!r_out_valid || i_ready);
    // Final report: no more hits, or the per-byte report limit reached
    assign w_last  = (w_rest == '0) ||
                     (r_rpt == mptm_pkg::RPT_W'(mptm_pkg::MAX_REPORTS - 1));
    assign o_q_pop = i_q_valid && (!r_busy || (w_adv && w_last));

    assign o_valid       = r_out_valid;
    assign o_match_slot  = r_slot;
    assign o_start_index = r_start;
    assign o_last        = r_last;

    // Job sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mask <= '0;
            r_rpt  <= '0;
        end else if (o_q_pop) begin
            r_busy  <= 1'b1;
            r_mask  <= i_q_job.mask;
            r_count <= i_q_job.count;
            r_lens  <= i_q_job.lens;
            r_rpt   <= '0;
        end else if (w_adv && w_last) begin
            r_busy <= 1'b0;
            r_mask <= '0;
        end else if (w_adv) begin
            r_mask <= w_rest;
            r_rpt  <= r_rpt + 1'b1;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_slot  <= mptm_pkg::SLOT_W'(w_sel);
            r_start <= w_diff[mptm_pkg::INDEX_W-1:0];
            r_last  <= w_last;
        end
    end

    `MPTM_ASSERT_SAME(a_busy_has_hits, r_busy, r_mask != '0, "active job without pending hits")
    `MPTM_ASSERT_SAME(a_open_report, r_out_valid && !r_last, r_busy, "report sequence closed without last")

endmodule

// File: tb/tb_multi_pattern_text_matcher.sv
// ----------------------------------------------------------------------------
// tb_multi_pattern_text_matcher
// Self-checking bench for the multi-pattern text matcher: a short table of
// hand-picked requests, then random pattern loads, text bursts, planted
// pattern copies and restarts, with random gaps on the request side and
// random stalls on the report side. Every report is checked field by field
// against an in-bench predictor of pattern store and history, or a typed row's report.
// ----------------------------------------------------------------------------
module tb_multi_pattern_text_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DIR_ROWS     = 23;
    localparam int          RAND_ITEMS   = 87;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam longint unsigned COUNT_MAX = (64'd1 << mptm_pkg::POS_BITS) - 64'd1;

    // One report as the block presents it
    typedef struct packed {
        logic [mptm_pkg::SLOT_W-1:0]  slot;
        logic [mptm_pkg::INDEX_W-1:0] idx;
        logic                         last;
    } t_match_rpt;

    // One row of the directed request table
    typedef struct {
        mptm_pkg::t_func func;
        int              slot;
        int              pos;
        int              plen;
        int              dbyte;
        bit              typed;
        int              n_hits;
        int              hit_slot;
        int              hit_idx;
    } t_dir_row;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_ready;
    logic [mptm_pkg::FUNC_W-1:0]   i_func        = '0;
    logic [mptm_pkg::SLOT_W-1:0]   i_slot        = '0;
    logic [mptm_pkg::CPOS_W-1:0]   i_char_pos    = '0;
    logic [mptm_pkg::PLEN_W-1:0]   i_pattern_len = '0;
    logic [mptm_pkg::BYTE_W-1:0]   i_data_byte   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready   = 1'b1;
    logic [mptm_pkg::SLOT_W-1:0]   o_match_slot;
    logic [mptm_pkg::INDEX_W-1:0]  o_start_index;
    logic                          o_last;

    // Predictor state
    logic [7:0]      pat_mem [mptm_pkg::NUM_PATTERNS][mptm_pkg::MAX_PATTERN_LEN];
    bit              pat_written [mptm_pkg::NUM_PATTERNS][mptm_pkg::MAX_PATTERN_LEN];
    int              pat_len [mptm_pkg::NUM_PATTERNS];
    logic [7:0]      txt_hist [mptm_pkg::MAX_PATTERN_LEN];
    longint unsigned txt_count;

    t_match_rpt  step_hits[$];
    t_match_rpt  pending_matches[$];
    t_match_rpt  want_rpt;
    int          req_count   = 0;
    int          n_err       = 0;
    int unsigned cyc_count   = 0;
    int          stall_left  = 0;
    bit          idle_en     = 1'b1;
    bit          stall_en    = 1'b1;
    int          alpha [6];

    // Directed requests; typed rows carry their own expected report
    t_dir_row dir_tbl [DIR_ROWS] = '{
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'h00, 1, 0, 0, 0},  // all slots off after reset
        '{mptm_pkg::FUNC_RESTART,  7, 15, 31, 8'hFF, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_PAT_BYTE, 0,  0,  0, 8'h00, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_PAT_BYTE, 0,  1,  0, 8'hFF, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_PAT_LEN,  0,  0,  2, 8'h00, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'h00, 1, 0, 0, 0},  // history shorter
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'hFF, 1, 1, 0, 0},
        '{mptm_pkg::FUNC_PAT_BYTE, 7,  0,  0, 8'h00, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_PAT_BYTE, 7,  1,  0, 8'hFF, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_PAT_BYTE, 3, 15, 31, 8'hA5, 0, 0, 0, 0},  // last byte position
        '{mptm_pkg::FUNC_PAT_LEN,  7,  0,  2, 8'h00, 0, 0, 0, 0},  // duplicate of slot 0
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'h00, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'hFF, 0, 0, 0, 0},  // both duplicates report
        '{mptm_pkg::FUNC_PAT_LEN,  0,  0,  0, 8'h00, 0, 0, 0, 0},  // disable slot 0
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'h00, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'hFF, 1, 1, 7, 4},
        '{mptm_pkg::FUNC_RESTART,  0,  0,  0, 8'h00, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'hFF, 1, 0, 0, 0},  // history cleared
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'h00, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'hFF, 1, 1, 7, 1},  // index from restart
        '{mptm_pkg::FUNC_PAT_BYTE, 3,  0,  0, 8'hFF, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_PAT_LEN,  3,  0,  1, 8'h00, 0, 0, 0, 0},
        '{mptm_pkg::FUNC_TEXT,     0,  0,  0, 8'hFF, 0, 0, 0, 0}
    };

    multi_pattern_text_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_slot        (i_slot),
        .i_char_pos    (i_char_pos),
        .i_pattern_len (i_pattern_len),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_match_slot  (o_match_slot),
        .o_start_index (o_start_index),
        .o_last        (o_last)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short pauses, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Predictor: applies one request and collects the reports it causes
    function automatic void matcher_step(mptm_pkg::t_func f, int s, int p, int l, int b);
        int  k;
        int  i;
        int  wlen;
        bit  hit;
        step_hits.delete();
        case (f)
            mptm_pkg::FUNC_PAT_BYTE: pat_mem[s][p] = 8'(b);
            mptm_pkg::FUNC_PAT_LEN: begin
                pat_len[s] = (l > mptm_pkg::MAX_PATTERN_LEN) ? mptm_pkg::MAX_PATTERN_LEN : l;
            end
            mptm_pkg::FUNC_RESTART: begin
                foreach (txt_hist[i]) txt_hist[i] = 8'h00;
                txt_count = 0;
            end
            default: begin
                // shift in the new byte, count saturates
                for (i = mptm_pkg::MAX_PATTERN_LEN - 1; i > 0; i--) txt_hist[i] = txt_hist[i-1];
                txt_hist[0] = 8'(b);
                if (txt_count < COUNT_MAX) txt_count++;
                for (k = 0; k < mptm_pkg::NUM_PATTERNS &&
                            step_hits.size() < mptm_pkg::MAX_REPORTS; k++) begin
                    wlen = pat_len[k];
                    if (wlen != 0 && txt_count >= 64'(wlen)) begin
                        hit = 1'b1;
                        for (i = 0; i < wlen; i++)
                            if (pat_mem[k][i] != txt_hist[wlen-1-i]) hit = 1'b0;
                        if (hit)
                            step_hits.insert(step_hits.size(),
                                '{mptm_pkg::SLOT_W'(k),
                                  mptm_pkg::INDEX_W'(txt_count - 64'(wlen)), 1'b0});
                    end
                end
                if (step_hits.size() > 0) step_hits[step_hits.size()-1].last = 1'b1;
            end
        endcase
    endfunction

    // Present one request, wait for it to be taken, queue what it should report
    task automatic drive_request(input mptm_pkg::t_func f, input int s, input int p,
                                 input int l, input int b, input bit typed, input int tn,
                                 input int ts, input int ti);
        int gap;
        i_in_valid    <= 1'b1;
        i_func        <= f;
        i_slot        <= mptm_pkg::SLOT_W'(s);
        i_char_pos    <= mptm_pkg::CPOS_W'(p);
        i_pattern_len <= mptm_pkg::PLEN_W'(l);
        i_data_byte   <= mptm_pkg::BYTE_W'(b);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        req_count++;
        if (f == mptm_pkg::FUNC_PAT_BYTE) pat_written[s & 7][p & 15] = 1'b1;
        matcher_step(f, s & 7, p & 15, l & 31, b & 255);
        if (typed) begin
            step_hits.delete();
            if (tn != 0)
                step_hits.insert(step_hits.size(),
                    '{mptm_pkg::SLOT_W'(ts), mptm_pkg::INDEX_W'(ti), 1'b1});
        end
        foreach (step_hits[k]) begin
            pending_matches.insert(pending_matches.size(), step_hits[k]);
        end
        gap = (idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send(input mptm_pkg::t_func f, input int s, input int p, input int l,
                        input int b);
        drive_request(f, s, p, l, b, 1'b0, 0, 0, 0);
    endtask

    // Report-side backpressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_en && $urandom_range(0, 3) == 0) begin
            stall_left  <= idle_len() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Report checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_matches.size() == 0) begin
                $error("unexpected report: match_slot %0d start_index %0d last %0d",
                       o_match_slot, o_start_index, o_last);
                n_err++;
            end else begin
                want_rpt = pending_matches.pop_front();
                if (o_match_slot !== want_rpt.slot) begin
                    $error("match_slot: expected %0d, got %0d", want_rpt.slot, o_match_slot);
                    n_err++;
                end
                if (o_start_index !== want_rpt.idx) begin
                    $error("start_index: expected %0d, got %0d", want_rpt.idx, o_start_index);
                    n_err++;
                end
                if (o_last !== want_rpt.last) begin
                    $error("last: expected %0d, got %0d", want_rpt.last, o_last);
                    n_err++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count == CYCLE_LIMIT) begin
            $display("multi_pattern_text_matcher: mismatch");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int  r;
        int  k;
        int  s;
        int  n;
        int  raw;
        int  eff;
        int  b;
        int  item_base;
        bit  ok;
        bit  first;

        foreach (pat_len[i]) pat_len[i] = 0;
        foreach (txt_hist[i]) txt_hist[i] = 8'h00;
        foreach (pat_mem[i, j]) begin
            pat_mem[i][j]     = 8'h00;
            pat_written[i][j] = 1'b0;
        end
        txt_count = 0;
        alpha[0]  = 8'h00;
        alpha[1]  = 8'hFF;
        for (k = 2; k < 6; k++) alpha[k] = $urandom_range(0, 255);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_tbl[i])
            drive_request(dir_tbl[i].func, dir_tbl[i].slot, dir_tbl[i].pos,
                          dir_tbl[i].plen, dir_tbl[i].dbyte, dir_tbl[i].typed,
                          dir_tbl[i].n_hits, dir_tbl[i].hit_slot, dir_tbl[i].hit_idx);

        // random traffic, biased toward patterns the text will actually hit
        item_base = req_count;
        first     = 1'b1;
        while (req_count - item_base < RAND_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                idle_en  = $urandom_range(0, 1);
                stall_en = $urandom_range(0, 1);
            end
            r = $urandom_range(0, 99);
            if (first || r >= 97) begin
                // every slot holds the same one-byte pattern: eight reports at once
                b = alpha[$urandom_range(0, 5)];
                for (s = 0; s < mptm_pkg::NUM_PATTERNS; s++) begin
                    send(mptm_pkg::FUNC_PAT_BYTE, s, 0, $urandom, b);
                    send(mptm_pkg::FUNC_PAT_LEN, s, $urandom, 1, $urandom);
                end
                send(mptm_pkg::FUNC_TEXT, $urandom, $urandom, $urandom, b);
                first = 1'b0;
            end else if (r < 20) begin
                // load a pattern, then its length (over-long lengths saturate)
                s   = $urandom_range(0, mptm_pkg::NUM_PATTERNS - 1);
                raw = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 31)
                                                  : $urandom_range(0, 7);
                eff = (raw > mptm_pkg::MAX_PATTERN_LEN) ? mptm_pkg::MAX_PATTERN_LEN : raw;
                for (k = 0; k < eff; k++)
                    send(mptm_pkg::FUNC_PAT_BYTE, s, k, $urandom, alpha[$urandom_range(0, 5)]);
                send(mptm_pkg::FUNC_PAT_LEN, s, $urandom, raw, $urandom);
            end else if (r < 45) begin
                // plant a copy of a stored pattern in the text
                s = $urandom_range(0, mptm_pkg::NUM_PATTERNS - 1);
                if (pat_len[s] != 0) begin
                    for (k = 0; k < pat_len[s]; k++)
                        send(mptm_pkg::FUNC_TEXT, $urandom, $urandom, $urandom, pat_mem[s][k]);
                end else begin
                    send(mptm_pkg::FUNC_TEXT, $urandom, $urandom, $urandom,
                         alpha[$urandom_range(0, 5)]);
                end
            end else if (r < 80) begin
                // burst of text, mostly from the small alphabet
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++) begin
                    b = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                    : alpha[$urandom_range(0, 5)];
                    send(mptm_pkg::FUNC_TEXT, $urandom, $urandom, $urandom, b);
                end
            end else if (r < 88) begin
                send(mptm_pkg::FUNC_RESTART, $urandom, $urandom, $urandom, $urandom);
            end else if ($urandom_range(0, 1) == 0) begin
                send(mptm_pkg::FUNC_PAT_BYTE, $urandom, $urandom, $urandom, $urandom);
            end else begin
                // stray length: only enable bytes that were written
                s   = $urandom_range(0, mptm_pkg::NUM_PATTERNS - 1);
                raw = $urandom_range(0, 31);
                eff = (raw > mptm_pkg::MAX_PATTERN_LEN) ? mptm_pkg::MAX_PATTERN_LEN : raw;
                ok  = 1'b1;
                for (k = 0; k < eff; k++)
                    if (!pat_written[s][k]) ok = 1'b0;
                send(mptm_pkg::FUNC_PAT_LEN, s, $urandom, ok ? raw : 0, $urandom);
            end
        end

        // drain
        i_in_valid <= 1'b0;
        stall_en = 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_err == 0) begin
            $display("multi_pattern_text_matcher: match");
        end else begin
            $display("multi_pattern_text_matcher: mismatch");
        end
        $finish;
    end

endmodule
